// ----- sv/bodlu_pkg.sv -----
// Shared types, constants and the locus decode function for the octal-decimal loci unit.
package bodlu_pkg;

   // Locus and digit geometry
   localparam int LOCUS_BITS   = 30;
   localparam int DIGIT_BITS   = 3;
   localparam int PEND_BITS    = LOCUS_BITS - 1;
   localparam int CNT_BITS     = 5;
   localparam int BYTE_BITS    = 8;
   localparam int ACC_BITS     = PEND_BITS + BYTE_BITS;
   localparam int INDEX_BITS   = 10;
   localparam int RSP_FLD_BITS = DIGIT_BITS + 3 * INDEX_BITS;
   localparam int RSP_DATA_W   = ((RSP_FLD_BITS + 7) / 8) * 8;

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH  = 4;

   // One accepted byte's worth of work: one or two loci
   typedef struct packed {
      logic [LOCUS_BITS-1:0] locus_a;
      logic                  final_a;
      logic                  has_b;
      logic [LOCUS_BITS-1:0] locus_b;
   } bodlu_job_type;

   // Three octal digits read as a decimal number
   function automatic logic [INDEX_BITS-1:0] dec3(input logic [3*DIGIT_BITS-1:0] d);
      logic [INDEX_BITS-1:0] h;
      logic [INDEX_BITS-1:0] t;
      logic [INDEX_BITS-1:0] o;
      h = INDEX_BITS'(d[8:6]);
      t = INDEX_BITS'(d[5:3]);
      o = INDEX_BITS'(d[2:0]);
      return h * 10'd100 + t * 10'd10 + o;
   endfunction

   // Locus to packed result data: selector, then three indexes, zero padded
   function automatic logic [RSP_DATA_W-1:0] locus_to_tdata(input logic [LOCUS_BITS-1:0] locus);
      logic [RSP_DATA_W-1:0] d;
      d = '0;
      d[2:0]   = locus[29:27];
      d[12:3]  = dec3(locus[26:18]);
      d[22:13] = dec3(locus[17:9]);
      d[32:23] = dec3(locus[8:0]);
      return d;
   endfunction

endpackage

// ----- sv/bodlu_front.sv -----
// Bit gearbox: appends request bytes to pending bits and cuts out full or padded loci.
module bodlu_front import bodlu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [BYTE_BITS-1:0] data_byte,
   input  logic                 last_byte,
   output logic                 push,
   output bodlu_job_type        job
);

   logic [PEND_BITS-1:0] pending_bits_ff, pending_bits_in;
   logic [CNT_BITS-1:0]  pending_count_ff, pending_count_in;

   logic [ACC_BITS-1:0]   acc_w;
   logic [CNT_BITS:0]     sum_w;
   logic                  full_w;
   logic [2:0]            rest_w;
   logic [ACC_BITS-1:0]   rem_w;
   logic [CNT_BITS-1:0]   left_w;
   logic [ACC_BITS-1:0]   part_shift_w;
   logic [LOCUS_BITS-1:0] full_locus_w;
   logic [LOCUS_BITS-1:0] part_locus_w;

   // Append byte, split off a full locus if one completes
   always_comb begin
      acc_w        = {pending_bits_ff, data_byte};
      sum_w        = {1'b0, pending_count_ff} + (CNT_BITS+1)'(BYTE_BITS);
      full_w       = sum_w >= (CNT_BITS+1)'(LOCUS_BITS);
      rest_w       = 3'(sum_w - (CNT_BITS+1)'(LOCUS_BITS));
      full_locus_w = LOCUS_BITS'(acc_w >> rest_w);
      if (full_w) begin
         rem_w  = acc_w & ((ACC_BITS'(1) << rest_w) - ACC_BITS'(1));
         left_w = CNT_BITS'(rest_w);
      end else begin
         rem_w  = acc_w;
         left_w = sum_w[CNT_BITS-1:0];
      end
      // leftover bits moved to the top of a locus, zeros to the right
      part_shift_w = rem_w << (CNT_BITS'(LOCUS_BITS) - left_w);
      part_locus_w = part_shift_w[LOCUS_BITS-1:0];
   end

   // Job sent to the queue
   always_comb begin
      push        = accept && (full_w || last_byte);
      job.locus_b = part_locus_w;
      if (full_w) begin
         job.locus_a = full_locus_w;
         job.final_a = last_byte && (left_w == '0);
         job.has_b   = last_byte && (left_w != '0);
      end else begin
         job.locus_a = part_locus_w;
         job.final_a = 1'b1;
         job.has_b   = 1'b0;
      end
   end

   // Pending state update; stream end clears it
   always_comb begin
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      if (accept) begin
         if (last_byte) begin
            pending_bits_in  = '0;
            pending_count_in = '0;
         end else begin
            pending_bits_in  = rem_w[PEND_BITS-1:0];
            pending_count_in = left_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
      end else begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
      end
   end

endmodule

// ----- sv/bodlu_queue.sv -----
// Small job queue between the gearbox and the result stage.
module bodlu_queue import bodlu_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  bodlu_job_type push_job,
   output logic          in_ready,
   input  logic          pop,
   output logic          out_valid,
   output bodlu_job_type out_job
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bodlu_job_type   mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- sv/bodlu_back.sv -----
// Result stage: decodes loci into selector and decimal indexes, one response per cycle while rsp_tready allows.
module bodlu_back import bodlu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  bodlu_job_type         q_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  b_pend_ff, b_pend_in;
   logic [LOCUS_BITS-1:0] b_locus_ff, b_locus_in;
   logic                  out_free_w;

   assign out_free_w = !rsp_valid_ff || rsp_tready;
   assign pop        = q_valid && !b_pend_ff && out_free_w;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Output register load: held second locus first, then the queue head
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      b_pend_in    = b_pend_ff;
      b_locus_in   = b_locus_ff;
      if (out_free_w) begin
         if (b_pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = locus_to_tdata(b_locus_ff);
            rsp_last_in  = 1'b1;
            b_pend_in    = 1'b0;
         end else if (q_valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = locus_to_tdata(q_job.locus_a);
            rsp_last_in  = q_job.final_a;
            b_pend_in    = q_job.has_b;
            b_locus_in   = q_job.locus_b;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         b_pend_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         b_pend_ff    <= b_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      b_locus_ff  <= b_locus_in;
   end

endmodule

// ----- sv/bytes_to_octal_decimal_loci_unit.sv -----
// Top level of the byte stream to octal-decimal loci unit.
// Takes one byte per cycle, MSB first, and packs the bits into 30-bit loci; each locus
// comes out as a 3-bit kind selector and three indexes 000-777 (three octal digits read
// as decimal). On the byte flagged by req_tlast a partial locus is zero padded, the last
// locus carries rsp_tlast, and the bit state restarts for the next stream. A byte enters
// every cycle while the job queue has room; responses leave one per cycle while rsp_tready
// is high, and a stream end with two loci holds the back side for its second locus, which
// the queue absorbs. A request passes the queue write and then the output register.
module bytes_to_octal_decimal_loci_unit import bodlu_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_BITS-1:0]  req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] kind_selector, [12:3] index_one,
                                              // [22:13] index_two, [32:23] index_three
   output logic                  rsp_tlast    // final_locus
);

   logic          accept_w;
   logic          push_w;
   bodlu_job_type push_job_w;
   logic          q_ready_w;
   logic          q_valid_w;
   bodlu_job_type q_job_w;
   logic          pop_w;

   assign req_tready = q_ready_w;
   assign accept_w   = req_tvalid && q_ready_w;

   bodlu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept_w),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .push      (push_w),
      .job       (push_job_w)
   );

   bodlu_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_w),
      .push_job  (push_job_w),
      .in_ready  (q_ready_w),
      .pop       (pop_w),
      .out_valid (q_valid_w),
      .out_job   (q_job_w)
   );

   bodlu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid_w),
      .q_job      (q_job_w),
      .pop        (pop_w),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // a stream end always produces a job
   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |-> push_w)
      else $error("stream end produced no job");

   // queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_w |-> q_ready_w)
      else $error("job queue overflow");

   // pop only from a non-empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_w |-> q_valid_w)
      else $error("job queue underflow");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");
`endif

endmodule

// ----- dv/loci_compare.sv -----
// Checker for the loci unit: watches both channels, predicts each locus and compares it.
`timescale 1ns / 1ps

module loci_compare
   import bodlu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [BYTE_BITS-1:0]  req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   output int                    mismatch_count,
   output int                    loci_outstanding
);

   // One predicted locus as it should leave the block
   typedef struct packed {
      logic [DIGIT_BITS-1:0] kind;
      logic [INDEX_BITS-1:0] idx_one;
      logic [INDEX_BITS-1:0] idx_two;
      logic [INDEX_BITS-1:0] idx_three;
      logic                  closes;
   } locus_result_type;

   // Stream bits not yet in a locus, right-aligned, and how many are valid
   logic [PEND_BITS-1:0] held_bits;
   int                   held_count;
   locus_result_type     expected_loci[$];
   int                   errs;

   // Three octal digits, most significant first, read as a decimal number
   function automatic logic [INDEX_BITS-1:0] octal_as_decimal(input logic [8:0] group);
      int v;
      v = 0;
      for (int i = 2; i >= 0; i--)
         v = v * 10 + int'(group[3*i +: 3]);
      return INDEX_BITS'(v);
   endfunction

   function automatic locus_result_type split_locus(input logic [LOCUS_BITS-1:0] locus,
                                                    input logic closes);
      locus_result_type r;
      r.kind      = locus[29:27];
      r.idx_one   = octal_as_decimal(locus[26:18]);
      r.idx_two   = octal_as_decimal(locus[17:9]);
      r.idx_three = octal_as_decimal(locus[8:0]);
      r.closes    = closes;
      return r;
   endfunction

   // Put one predicted locus at the tail of the expected list
   task automatic add_expected(input locus_result_type r);
      expected_loci.insert(expected_loci.size(), r);
   endtask

   // Append one byte to the bit store; queue any locus it completes
   task automatic absorb_byte(input logic [BYTE_BITS-1:0] b, input logic is_last);
      logic [ACC_BITS-1:0] acc;
      int                  bits;
      int                  rest;
      acc  = {held_bits, b};
      bits = held_count + BYTE_BITS;
      if (bits >= LOCUS_BITS) begin
         rest = bits - LOCUS_BITS;
         add_expected(split_locus(LOCUS_BITS'(acc >> rest), is_last && (rest == 0)));
         acc  = acc & ((ACC_BITS'(1) << rest) - ACC_BITS'(1));
         bits = rest;
      end
      if (is_last) begin
         // partial locus is zero padded on the right
         if (bits > 0)
            add_expected(split_locus(LOCUS_BITS'(acc << (LOCUS_BITS - bits)), 1'b1));
         held_bits  = '0;
         held_count = 0;
      end else begin
         held_bits  = acc[PEND_BITS-1:0];
         held_count = bits;
      end
   endtask

   function void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errs++;
      end
   endfunction

   // Predict on every accepted request, compare on every accepted response
   always @(posedge clock) begin
      locus_result_type want;
      if (reset) begin
         held_bits  = '0;
         held_count = 0;
         expected_loci.delete();
      end else begin
         if (req_tvalid && req_tready)
            absorb_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_loci.size() == 0) begin
               $error("locus with no request behind it: tdata %h, tlast %b",
                      rsp_tdata, rsp_tlast);
               errs++;
            end else begin
               want = expected_loci.pop_front();
               check_field("kind_selector", want.kind, rsp_tdata[2:0]);
               check_field("index_one", want.idx_one, rsp_tdata[12:3]);
               check_field("index_two", want.idx_two, rsp_tdata[22:13]);
               check_field("index_three", want.idx_three, rsp_tdata[32:23]);
               check_field("tdata padding", 0, int'(rsp_tdata[RSP_DATA_W-1:RSP_FLD_BITS]));
               check_field("final_locus", want.closes, rsp_tlast);
            end
         end
      end
      mismatch_count   <= errs;
      loci_outstanding <= expected_loci.size();
   end

endmodule

// ----- dv/testbench.sv -----
// Testbench top for the loci unit: clock, reset, byte stream stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
   import bodlu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_BITS-1:0]  req_tdata;   // [7:0] data_byte
   logic                  req_tlast;   // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [2:0] kind_selector, [12:3] index_one,
                                       // [22:13] index_two, [32:23] index_three
   logic                  rsp_tlast;   // final_locus

   int mismatch_count;
   int loci_outstanding;
   int send_idle;
   int recv_idle;
   int hold_asks;
   int bytes_sent;
   int cycle_count;

   bytes_to_octal_decimal_loci_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   loci_compare scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .mismatch_count   (mismatch_count),
      .loci_outstanding (loci_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Offer one byte, with random idle cycles ahead of it, and wait for acceptance
   task automatic push_byte(input logic [BYTE_BITS-1:0] b, input logic is_last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // One stream of random bytes; lengths cover every bit residue at the end
   task automatic push_stream();
      int len;
      logic [BYTE_BITS-1:0] b;
      if ($urandom_range(9) == 0)
         len = $urandom_range(31, 90);
      else
         len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(7) == 0)
            b = $urandom_range(1) ? 8'hFF : 8'h00;
         else
            b = BYTE_BITS'($urandom_range(255));
         push_byte(b, i == len - 1);
      end
   endtask

   task automatic run_phase(input int snd, input int rcv, input int target);
      send_idle = snd;
      recv_idle = rcv;
      while (bytes_sent < target)
         push_stream();
   endtask

   // Stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      send_idle  = 10;
      recv_idle  = 88;
      hold_asks  = 0;
      bytes_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single byte streams: padded partial locus only
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      // 32 bits: one full locus, then a two-bit padded one
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      // 24 bits: partial locus with mixed digits
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h7E, 1'b1);
      // 120 bits of ones: four full loci, the last one exact and final, all indexes 777
      for (int i = 0; i < 15; i++)
         push_byte(8'hFF, i == 14);

      run_phase(10, 88, 350);
      run_phase(88, 10, 700);
      // long receiver hold-off while the sender keeps offering
      hold_asks++;
      run_phase(0, 0, 1030);

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (2) @(posedge clock);
      while (loci_outstanding != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && loci_outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
